// ===== rtl/gha_pkg.sv =====
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and constants of the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int unsigned HANDLE_W  = 32;
  localparam int unsigned GEN_W     = 12;
  localparam int unsigned IDX_W     = 20;  // index field of a handle
  localparam int unsigned TYPE_W    = 8;
  localparam int unsigned SLOTNUM_W = 10;
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned ACTION_W  = 2;

  // The in-use bitmap is kept as rows of ROW_W bits.
  localparam int unsigned ROW_W     = 32;
  localparam int unsigned ROW_BIT_W = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_RESERVE = 2'd0,
    ACT_RESOLVE = 2'd1,
    ACT_EVICT   = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  // One word of the slot memory.
  typedef struct packed {
    logic [GEN_W-1:0]  live_gen;
    logic [GEN_W-1:0]  next_gen;
    logic [TYPE_W-1:0] slot_type;
  } slot_entry_t;

  localparam int unsigned ENTRY_W = $bits(slot_entry_t);

endpackage

// ===== rtl/generational_handle_allocator.sv =====
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Slot table that hands out generation-tagged handles and resolves and
// evicts them, built around a slot memory and an in-use bitmap memory.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                      Payload
//  --------  -----------------------------  -------------------------------
//  request   start / busy                   action_i, handle_i, entity_type_i
//  result    done_o (one-cycle strobe)      status_o, result_handle_o,
//                                           slot_number_o, slot_type_o,
//                                           live_count_o
//  config    cfg_valid_i / cfg_ready_o      cfg_data_i (null type code)
//
// A reserve passes through the look, pick and commit states before the result
// strobe, a resolve or evict through look and commit, and a request that falls
// straight to the null slot (table full, index zero or out of range, unused
// action) ends in look. The states follow the chain of registered memory reads:
// bitmap row, then slot entry. A new item may be accepted in the cycle its
// predecessor's result is shown. Reset needs no clearing pass; the receiver cannot stall the result.
//
// State layout:
//   The slot memory holds, per slot, the live generation, the next generation
//   and the stored type. The in-use flags live in a bitmap memory of 32-bit
//   rows. A valid flop per row makes an unwritten row read as its reset value
//   (only the null slot set), and a per-row full flag lets the reserve pick
//   the first row with a free slot without reading the bitmap.
//   Slots are always reserved lowest first, so the slots that were ever
//   reserved form a prefix below a high-water mark. A slot at or above the
//   mark has a next generation of zero regardless of what the slot memory
//   holds; its live generation and type are never read before a reserve
//   writes them, because they are only used once the slot is in use.
//   Bits of the last row beyond the slot count read as in use so they are
//   never handed out.
// ----------------------------------------------------------------------------
module generational_handle_allocator
  import gha_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  start,
  output logic                  busy,
  input  logic [ACTION_W-1:0]   action_i,
  input  logic [HANDLE_W-1:0]   handle_i,
  input  logic [TYPE_W-1:0]     entity_type_i,

  output logic                  done_o,
  output logic                  status_o,
  output logic [HANDLE_W-1:0]   result_handle_o,
  output logic [SLOTNUM_W-1:0]  slot_number_o,
  output logic [TYPE_W-1:0]     slot_type_o,
  output logic [COUNT_W-1:0]    live_count_o,

  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [TYPE_W-1:0]     cfg_data_i
);

  localparam int unsigned ROWS  = (SLOT_COUNT + ROW_W - 1) / ROW_W;
  localparam int unsigned RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned SW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned HWM_W = SW + 1;
  localparam int unsigned CMP_W = IDX_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_PICK,
    ST_COMMIT
  } state_e;

  // Control state.
  state_e               state_q, state_d;
  logic                 done_q, done_d;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic [HWM_W-1:0]     hwm_q, hwm_d;
  logic [ROWS-1:0]      row_valid_q, row_valid_d;
  logic [ROWS-1:0]      row_full_q, row_full_d;
  logic [TYPE_W-1:0]    null_type_q;

  // Request and working registers.
  logic [ACTION_W-1:0]  action_q, action_d;
  logic [HANDLE_W-1:0]  handle_q, handle_d;
  logic [TYPE_W-1:0]    type_q, type_d;
  logic [RW-1:0]        row_q, row_d;
  logic [ROW_BIT_W-1:0] bit_q, bit_d;

  // Result registers.
  logic                 status_q, status_d;
  logic [HANDLE_W-1:0]  rhandle_q, rhandle_d;
  logic [SLOTNUM_W-1:0] slotnum_q, slotnum_d;
  logic [TYPE_W-1:0]    rtype_q, rtype_d;
  logic [COUNT_W-1:0]   rcount_q, rcount_d;

  // Memory ports.
  logic                 bm_we, bm_re;
  logic [RW-1:0]        bm_waddr, bm_raddr;
  logic [ROW_W-1:0]     bm_wdata, bm_rdata;
  logic                 sl_we, sl_re;
  logic [SW-1:0]        sl_waddr, sl_raddr;
  slot_entry_t          sl_wdata;
  logic [ENTRY_W-1:0]   sl_rdata;

  // Search results.
  logic                 row_found;
  logic [RW-1:0]        row_free;
  logic                 bit_found;
  logic [ROW_BIT_W-1:0] bit_free;

  // Decoded views.
  logic [ROW_W-1:0]     pad_mask;
  logic [ROW_W-1:0]     row_word;
  logic [IDX_W-1:0]     cur_idx;
  logic [IDX_W-1:0]     req_idx;
  logic [IDX_W-1:0]     pick_idx;
  slot_entry_t          entry;
  logic [GEN_W-1:0]     new_gen;
  logic                 slot_live;
  logic                 handle_match;

  gha_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i (bm_waddr),
    .wdata_i (bm_wdata),
    .re_i    (bm_re),
    .raddr_i (bm_raddr),
    .rdata_o (bm_rdata)
  );

  gha_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (sl_we),
    .waddr_i (sl_waddr),
    .wdata_i (sl_wdata),
    .re_i    (sl_re),
    .raddr_i (sl_raddr),
    .rdata_o (sl_rdata)
  );

  // First row that still has a free slot.
  gha_lowest_zero #(
    .WIDTH (ROWS)
  ) u_row_search (
    .bits_i  (row_full_q),
    .found_o (row_found),
    .idx_o   (row_free)
  );

  // First free slot within the row just read.
  gha_lowest_zero #(
    .WIDTH (ROW_W)
  ) u_bit_search (
    .bits_i  (row_word),
    .found_o (bit_found),
    .idx_o   (bit_free)
  );

  // Slots of the current row that lie beyond the table read as in use.
  always_comb begin
    for (int j = 0; j < ROW_W; j++) begin
      pad_mask[j] = ((CMP_W'(row_q) << ROW_BIT_W) + CMP_W'(j)) >= CMP_W'(SLOT_COUNT);
    end
  end

  // Bitmap row as it stands; an unwritten row holds its reset contents.
  always_comb begin
    if (row_valid_q[row_q]) begin
      row_word = bm_rdata | pad_mask;
    end else begin
      row_word = pad_mask | ((row_q == '0) ? ROW_W'(1) : '0);
    end
  end

  assign cur_idx  = (IDX_W'(row_q) << ROW_BIT_W) | IDX_W'(bit_q);
  assign pick_idx = (IDX_W'(row_q) << ROW_BIT_W) | IDX_W'(bit_free);
  assign req_idx  = handle_q[IDX_W-1:0];
  assign entry    = slot_entry_t'(sl_rdata);

  // Slots at or above the high-water mark were never reserved: generation zero.
  assign new_gen = ({1'b0, cur_idx} < CMP_W'(hwm_q)) ? entry.next_gen : '0;

  assign slot_live    = row_word[bit_q];
  assign handle_match = slot_live && (entry.live_gen == handle_q[HANDLE_W-1:IDX_W]);

  always_comb begin
    state_d     = state_q;
    done_d      = 1'b0;
    count_d     = count_q;
    hwm_d       = hwm_q;
    row_valid_d = row_valid_q;
    row_full_d  = row_full_q;
    action_d    = action_q;
    handle_d    = handle_q;
    type_d      = type_q;
    row_d       = row_q;
    bit_d       = bit_q;
    status_d    = status_q;
    rhandle_d   = rhandle_q;
    slotnum_d   = slotnum_q;
    rtype_d     = rtype_q;
    rcount_d    = rcount_q;

    bm_we    = 1'b0;
    bm_waddr = row_q;
    bm_wdata = row_word;
    bm_re    = 1'b0;
    bm_raddr = row_q;
    sl_we    = 1'b0;
    sl_waddr = SW'(cur_idx);
    sl_wdata = '{live_gen: new_gen, next_gen: new_gen + GEN_W'(1), slot_type: type_q};
    sl_re    = 1'b0;
    sl_raddr = SW'(req_idx);

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          action_d = action_i;
          handle_d = handle_i;
          type_d   = entity_type_i;
          state_d  = ST_LOOK;
        end
      end

      ST_LOOK: begin
        // Default outcome: the null slot, reported at once.
        status_d  = 1'b1;
        rhandle_d = '0;
        slotnum_d = '0;
        rtype_d   = null_type_q;
        rcount_d  = count_q;
        case (action_e'(action_q))
          ACT_RESERVE: begin
            if (row_found) begin
              bm_re    = 1'b1;
              bm_raddr = row_free;
              row_d    = row_free;
              state_d  = ST_PICK;
            end else begin
              done_d  = 1'b1;
              state_d = ST_IDLE;
            end
          end
          ACT_RESOLVE, ACT_EVICT: begin
            if ((req_idx == '0) || ({1'b0, req_idx} >= CMP_W'(SLOT_COUNT))) begin
              done_d  = 1'b1;
              state_d = ST_IDLE;
            end else begin
              bm_re    = 1'b1;
              bm_raddr = RW'(req_idx >> ROW_BIT_W);
              sl_re    = 1'b1;
              row_d    = RW'(req_idx >> ROW_BIT_W);
              bit_d    = req_idx[ROW_BIT_W-1:0];
              state_d  = ST_COMMIT;
            end
          end
          default: begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end
        endcase
      end

      ST_PICK: begin
        // The row was not full, so a free bit is always found here.
        bit_d    = bit_free;
        sl_re    = bit_found;
        sl_raddr = SW'(pick_idx);
        state_d  = ST_COMMIT;
      end

      ST_COMMIT: begin
        done_d    = 1'b1;
        state_d   = ST_IDLE;
        status_d  = 1'b1;
        rhandle_d = '0;
        slotnum_d = '0;
        rtype_d   = null_type_q;
        rcount_d  = count_q;
        if (action_e'(action_q) == ACT_RESERVE) begin
          sl_we    = 1'b1;
          bm_we    = 1'b1;
          bm_wdata = row_word | (ROW_W'(1) << bit_q);
          row_valid_d[row_q] = 1'b1;
          row_full_d[row_q]  = &bm_wdata;
          if ({1'b0, cur_idx} >= CMP_W'(hwm_q)) begin
            hwm_d = hwm_q + HWM_W'(1);
          end
          count_d   = count_q + COUNT_W'(1);
          status_d  = 1'b0;
          rhandle_d = {new_gen, cur_idx};
          slotnum_d = cur_idx[SLOTNUM_W-1:0];
          rtype_d   = type_q;
          rcount_d  = count_q + COUNT_W'(1);
        end else if (handle_match) begin
          rhandle_d = handle_q;
          slotnum_d = cur_idx[SLOTNUM_W-1:0];
          rtype_d   = entry.slot_type;
          if (action_e'(action_q) == ACT_RESOLVE) begin
            status_d = 1'b0;
          end else if (entry.slot_type != null_type_q) begin
            // Evict: clear the in-use bit and report the slot as it was.
            bm_we    = 1'b1;
            bm_wdata = row_word & ~(ROW_W'(1) << bit_q);
            row_valid_d[row_q] = 1'b1;
            row_full_d[row_q]  = 1'b0;
            count_d  = count_q - COUNT_W'(1);
            rcount_d = count_q - COUNT_W'(1);
            status_d = 1'b0;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      done_q      <= 1'b0;
      count_q     <= '0;
      hwm_q       <= HWM_W'(1);
      row_valid_q <= '0;
      row_full_q  <= '0;
      null_type_q <= '0;
      status_q    <= 1'b0;
      rhandle_q   <= '0;
      slotnum_q   <= '0;
      rtype_q     <= '0;
      rcount_q    <= '0;
    end else begin
      state_q     <= state_d;
      done_q      <= done_d;
      count_q     <= count_d;
      hwm_q       <= hwm_d;
      row_valid_q <= row_valid_d;
      row_full_q  <= row_full_d;
      status_q    <= status_d;
      rhandle_q   <= rhandle_d;
      slotnum_q   <= slotnum_d;
      rtype_q     <= rtype_d;
      rcount_q    <= rcount_d;
      if (cfg_valid_i) begin
        null_type_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    action_q  <= action_d;
    handle_q  <= handle_d;
    type_q    <= type_d;
    row_q     <= row_d;
    bit_q     <= bit_d;
  end

  assign busy            = (state_q != ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign result_handle_o = rhandle_q;
  assign slot_number_o   = slotnum_q;
  assign slot_type_o     = rtype_q;
  assign live_count_o    = rcount_q;

endmodule

// ===== rtl/gha_ram.sv =====
// ----------------------------------------------------------------------------
// gha_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gha_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gha_lowest_zero.sv =====
// ----------------------------------------------------------------------------
// gha_lowest_zero
// Finds the lowest clear bit of a vector.
// ----------------------------------------------------------------------------
module gha_lowest_zero #(
  parameter int unsigned WIDTH = 32,
  localparam int unsigned IW   = (WIDTH > 1) ? $clog2(WIDTH) : 1
) (
  input  logic [WIDTH-1:0] bits_i,
  output logic             found_o,
  output logic [IW-1:0]    idx_o
);

  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    // Walk from the top so the lowest clear bit is the one that sticks.
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (!bits_i[i]) begin
        found_o = 1'b1;
        idx_o   = IW'(i);
      end
    end
  end

endmodule
